// File: design/ppts_pkg.sv
// Package for the periodic priority task scheduler: commands, status codes,
// slot states, FSM states and the controller/datapath command and status structs.
package ppts_pkg;

    localparam int SLOTS_DEF = 8;
    localparam logic [15:0] TICK_WRAP = 16'd65000;
    localparam logic [6:0] MAX_PRI_RESET = 7'd10;

    typedef enum logic [1:0] {
        CMD_CREATE = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_SCHED  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NULL_ID   = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        SL_DORMANT = 2'd0,
        SL_READY   = 2'd1,
        SL_RUNNING = 2'd2,
        SL_WAITING = 2'd3
    } t_slot_state;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DIV,
        FSM_COMMIT,
        FSM_OUT
    } t_fsm;

    typedef struct packed {
        logic load;      // capture request and run create/delete/tick
        logic scan_init; // start a schedule pass
        logic slot_step; // evaluate current slot (no division needed)
        logic div_start; // start remainder for current slot
        logic div_step;  // one remainder iteration
        logic div_end;   // evaluate current slot using remainder
        logic commit;    // mark winner running, build result
    } t_ctl;

    typedef struct packed {
        logic is_sched;
        logic need_div;  // current slot is waiting or running with nonzero period
        logic last_slot;
        logic div_done;
    } t_sts;

endpackage

// File: design/ppts_ctrl.sv
// Controller FSM for the task scheduler: sequences the slot scan and the
// remainder unit, and owns the request/result handshakes. Uses ppts_pkg.
module ppts_ctrl
    import ppts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    t_fsm r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            FSM_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctl.load = 1'b1;
                    if (i_sts.is_sched) begin
                        o_ctl.scan_init = 1'b1;
                        n_state = FSM_SCAN;
                    end else begin
                        n_state = FSM_OUT;
                    end
                end
            end
            FSM_SCAN: begin
                if (i_sts.need_div) begin
                    o_ctl.div_start = 1'b1;
                    n_state = FSM_DIV;
                end else begin
                    o_ctl.slot_step = 1'b1;
                    if (i_sts.last_slot) begin
                        n_state = FSM_COMMIT;
                    end
                end
            end
            FSM_DIV: begin
                if (i_sts.div_done) begin
                    o_ctl.div_end = 1'b1;
                    n_state = i_sts.last_slot ? FSM_COMMIT : FSM_SCAN;
                end else begin
                    o_ctl.div_step = 1'b1;
                end
            end
            FSM_COMMIT: begin
                o_ctl.commit = 1'b1;
                n_state = FSM_OUT;
            end
            FSM_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = FSM_IDLE;
                end
            end
            default: n_state = FSM_IDLE;
        endcase
    end

endmodule

// File: design/ppts_dp.sv
// Datapath for the task scheduler: slot table, tick counter, bit-serial
// remainder unit and result registers. Uses ppts_pkg; driven by ppts_ctrl.
module ppts_dp
    import ppts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_period,
    input  t_ctl        i_ctl,
    output t_sts        o_sts,
    output logic [1:0]  o_status,
    output logic        o_dispatched,
    output logic [2:0]  o_slot_index,
    output logic [7:0]  o_dispatched_task
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [7:0]        r_task  [SLOTS];
    logic [6:0]        r_pri   [SLOTS];
    logic [15:0]       r_per   [SLOTS];
    t_slot_state       r_st    [SLOTS];
    logic [15:0]       r_tick;
    logic [6:0]        r_max_pri;
    logic [SW-1:0]     r_idx;
    logic [6:0]        r_best_pri;
    logic [SW-1:0]     r_best;
    logic              r_found;
    logic [15:0]       r_rem;
    logic [15:0]       r_quo;
    logic [4:0]        r_cnt;
    logic [1:0]        r_status;
    logic              r_disp;
    logic [2:0]        r_slot;
    logic [7:0]        r_dtask;

    logic [SW-1:0] free_idx, match_idx;
    logic          free_hit, match_hit;
    logic [6:0]    clamp_pri;
    logic [16:0]   rem_sh;
    logic [15:0]   cur_per;
    t_slot_state   cur_st;
    t_slot_state   eval_st;
    logic          wake;
    logic [15:0]   tick_inc;

    always_comb begin
        free_idx  = '0;
        free_hit  = 1'b0;
        match_idx = '0;
        match_hit = 1'b0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (r_task[s] == 8'd0) begin
                free_idx = SW'(s);
                free_hit = 1'b1;
            end
            if (r_task[s] == i_task_id) begin
                match_idx = SW'(s);
                match_hit = 1'b1;
            end
        end
    end

    assign clamp_pri = (i_priority_req <= {1'b0, r_max_pri}) ? i_priority_req[6:0] : r_max_pri;
    assign cur_per   = r_per[r_idx];
    assign cur_st    = r_st[r_idx];
    assign rem_sh    = {r_rem, r_quo[15]};
    assign tick_inc  = r_tick + 16'd1;

    // running becomes waiting; waiting wakes when remainder is zero
    always_comb begin
        eval_st = (cur_st == SL_RUNNING) ? SL_WAITING : cur_st;
        wake    = i_ctl.div_end && (r_rem == 16'd0);
        if (eval_st == SL_WAITING && wake) begin
            eval_st = SL_READY;
        end
    end

    assign o_sts.is_sched  = (t_cmd'(i_cmd) == CMD_SCHED);
    assign o_sts.need_div  = (cur_st == SL_WAITING || cur_st == SL_RUNNING)
                             && (cur_per != 16'd0);
    assign o_sts.last_slot = (r_idx == SW'(SLOTS - 1));
    assign o_sts.div_done  = (r_cnt == 5'd16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_task[s] <= 8'd0;
                r_pri[s]  <= 7'd0;
                r_per[s]  <= 16'd0;
                r_st[s]   <= SL_DORMANT;
            end
            r_tick    <= 16'd1;
            r_max_pri <= MAX_PRI_RESET;
        end else begin
            if (i_cfg_we) begin
                r_max_pri <= i_cfg_data;
            end
            if (i_ctl.load) begin
                unique case (t_cmd'(i_cmd))
                    CMD_CREATE: begin
                        if (i_task_id != 8'd0 && free_hit) begin
                            r_task[free_idx] <= i_task_id;
                            r_per[free_idx]  <= i_period;
                            r_st[free_idx]   <= SL_READY;
                            r_pri[free_idx]  <= clamp_pri;
                        end
                    end
                    CMD_DELETE: begin
                        if (i_task_id != 8'd0 && match_hit) begin
                            r_task[match_idx] <= 8'd0;
                            r_per[match_idx]  <= 16'd0;
                            r_pri[match_idx]  <= 7'd0;
                            r_st[match_idx]   <= SL_DORMANT;
                        end
                    end
                    CMD_TICK: begin
                        r_tick <= (tick_inc == TICK_WRAP) ? 16'd1 : tick_inc;
                    end
                    CMD_SCHED: ;
                    default: ;
                endcase
            end
            if (i_ctl.slot_step || i_ctl.div_end) begin
                r_st[r_idx] <= eval_st;
            end
            if (i_ctl.commit && r_found) begin
                r_st[r_best] <= SL_RUNNING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_disp     <= 1'b0;
            r_slot     <= 3'd0;
            r_dtask    <= 8'd0;
            unique case (t_cmd'(i_cmd))
                CMD_CREATE: r_status <= (i_task_id == 8'd0) ? STS_NULL_ID :
                                        (free_hit ? STS_OK : STS_FULL);
                CMD_DELETE: r_status <= (i_task_id == 8'd0) ? STS_NULL_ID :
                                        (match_hit ? STS_OK : STS_NOT_FOUND);
                default:    r_status <= STS_OK;
            endcase
        end
        if (i_ctl.scan_init) begin
            r_idx      <= '0;
            r_best_pri <= 7'd0;
            r_best     <= '0;
            r_found    <= 1'b0;
        end
        if (i_ctl.div_start) begin
            r_rem <= 16'd0;
            r_quo <= r_tick;
            r_cnt <= 5'd0;
        end
        // restoring remainder, one bit per cycle
        if (i_ctl.div_step) begin
            r_rem <= (rem_sh >= {1'b0, cur_per}) ? 16'(rem_sh - {1'b0, cur_per})
                                                 : rem_sh[15:0];
            r_quo <= {r_quo[14:0], 1'b0};
            r_cnt <= r_cnt + 5'd1;
        end
        if (i_ctl.slot_step || i_ctl.div_end) begin
            if (eval_st == SL_READY && r_pri[r_idx] > r_best_pri) begin
                r_best_pri <= r_pri[r_idx];
                r_best     <= r_idx;
                r_found    <= 1'b1;
            end
            if (!o_sts.last_slot) begin
                r_idx <= r_idx + SW'(1);
            end
        end
        if (i_ctl.commit) begin
            r_disp  <= r_found;
            r_slot  <= r_found ? 3'(r_best) : 3'd0;
            r_dtask <= r_found ? r_task[r_best] : 8'd0;
        end
    end

    assign o_status          = r_status;
    assign o_dispatched      = r_disp;
    assign o_slot_index      = r_slot;
    assign o_dispatched_task = r_dtask;

endmodule

// File: design/periodic_priority_task_scheduler.sv
// Fixed-priority periodic task scheduler. One request is handled at a time.
// Create, delete and tick are done on acceptance; the result then waits to be
// taken. A schedule pass visits the slots one per cycle, except that each
// waiting or running slot with a nonzero period first runs its 16-bit
// bit-serial remainder (tick count modulo period). max_priority may be
// written while idle.
module periodic_priority_task_scheduler
    import ppts_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [7:0]  i_task_id,
    input  logic [7:0]  i_priority_req,
    input  logic [15:0] i_period,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_dispatched,
    output logic [2:0]  o_slot_index,
    output logic [7:0]  o_dispatched_task
);

    t_ctl ctl;
    t_sts sts;

    ppts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    ppts_dp #(.SLOTS(SLOTS)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_cmd),
        .i_task_id         (i_task_id),
        .i_priority_req    (i_priority_req),
        .i_period          (i_period),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .o_status          (o_status),
        .o_dispatched      (o_dispatched),
        .o_slot_index      (o_slot_index),
        .o_dispatched_task (o_dispatched_task)
    );

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("request taken while result pending");

    a_disp_sched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dispatched) |-> (o_status == STS_OK))
        else $error("dispatch with nonzero status");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_dispatched_task)))
        else $error("result changed while stalled");
`endif

endmodule

// File: tb/periodic_priority_task_scheduler_test.sv
// Testbench for the periodic priority task scheduler: a self-checking run of
// directed and random requests against an in-bench predictor of the slot table.
// Depends on ppts_pkg and the periodic_priority_task_scheduler RTL.
module periodic_priority_task_scheduler_test;
    import ppts_pkg::*;

    localparam int NSLOT = 8;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0] status;
        logic       dispatched;
        logic [2:0] slot_index;
        logic [7:0] dispatched_task;
    } t_reply;

    class sched_scoreboard;
        logic [7:0]  task_id_tbl[NSLOT];
        logic [6:0]  prio_tbl[NSLOT];
        logic [15:0] period_tbl[NSLOT];
        t_slot_state state_tbl[NSLOT];
        logic [15:0] ticks;
        logic [6:0]  max_prio;
        t_reply      pending[$];
        int          errors;

        function new();
            for (int s = 0; s < NSLOT; s++) begin
                task_id_tbl[s] = 0;
                prio_tbl[s] = 0;
                period_tbl[s] = 0;
                state_tbl[s] = SL_DORMANT;
            end
            ticks = 1;
            max_prio = MAX_PRI_RESET;
            errors = 0;
        endfunction

        function void note_request(t_cmd cmd, logic [7:0] id, logic [7:0] preq,
                                   logic [15:0] per);
            t_reply r;
            int best;
            logic [6:0] best_pri;
            r = '0;
            best = -1;
            best_pri = 0;
            case (cmd)
                CMD_CREATE: begin
                    if (id == 0) r.status = STS_NULL_ID;
                    else begin
                        r.status = STS_FULL;
                        for (int s = 0; s < NSLOT; s++) begin
                            if (task_id_tbl[s] == 0) begin
                                task_id_tbl[s] = id;
                                period_tbl[s] = per;
                                state_tbl[s] = SL_READY;
                                prio_tbl[s] = (preq <= {1'b0, max_prio}) ? preq[6:0] : max_prio;
                                r.status = STS_OK;
                                break;
                            end
                        end
                    end
                end
                CMD_DELETE: begin
                    if (id == 0) r.status = STS_NULL_ID;
                    else begin
                        r.status = STS_NOT_FOUND;
                        for (int s = 0; s < NSLOT; s++) begin
                            if (task_id_tbl[s] == id) begin
                                task_id_tbl[s] = 0;
                                period_tbl[s] = 0;
                                prio_tbl[s] = 0;
                                state_tbl[s] = SL_DORMANT;
                                r.status = STS_OK;
                                break;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    ticks = ticks + 16'd1;
                    if (ticks == TICK_WRAP) ticks = 1;
                end
                default: begin
                    for (int s = 0; s < NSLOT; s++) begin
                        if (state_tbl[s] == SL_RUNNING) state_tbl[s] = SL_WAITING;
                        if (state_tbl[s] == SL_WAITING && period_tbl[s] != 0 &&
                            ticks % period_tbl[s] == 0)
                            state_tbl[s] = SL_READY;
                        if (state_tbl[s] == SL_READY && prio_tbl[s] > best_pri) begin
                            best_pri = prio_tbl[s];
                            best = s;
                        end
                    end
                    if (best >= 0) begin
                        state_tbl[best] = SL_RUNNING;
                        r.dispatched = 1;
                        r.slot_index = best[2:0];
                        r.dispatched_task = task_id_tbl[best];
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_reply(t_reply got);
            t_reply want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected reply", 0, got);
                return;
            end
            want = pending.pop_front();
            if (got.status != want.status) report_mismatch("status", want.status, got.status);
            if (got.dispatched != want.dispatched)
                report_mismatch("dispatched", want.dispatched, got.dispatched);
            if (got.slot_index != want.slot_index)
                report_mismatch("slot_index", want.slot_index, got.slot_index);
            if (got.dispatched_task != want.dispatched_task)
                report_mismatch("dispatched_task", want.dispatched_task, got.dispatched_task);
        endfunction

        function void report_mismatch(string what, int want, int got);
            $display("MISMATCH %s: expected %0d got %0d", what, want, got);
            errors++;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [6:0]  i_cfg_data = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_cmd = 0;
    logic [7:0]  i_task_id = 0;
    logic [7:0]  i_priority_req = 0;
    logic [15:0] i_period = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [1:0]  o_status;
    logic        o_dispatched;
    logic [2:0]  o_slot_index;
    logic [7:0]  o_dispatched_task;

    sched_scoreboard board = new();
    int cycles = 0;

    periodic_priority_task_scheduler uut (.*);

    always #6 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge i_clk) begin
        t_reply got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            got.status = o_status;
            got.dispatched = o_dispatched;
            got.slot_index = o_slot_index;
            got.dispatched_task = o_dispatched_task;
            board.check_reply(got);
        end
    end

    // receiver: random stalls, occasional stall-free stretches
    initial begin
        int g;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                g = gap_len();
                if (g > 0) begin
                    i_ready <= 0;
                    repeat (g) @(negedge i_clk);
                end
            end
            i_ready <= 1;
            repeat ($urandom_range(0, 1) ? 1 : $urandom_range(1, 40)) @(negedge i_clk);
        end
    end

    task automatic send_request(t_cmd cmd, logic [7:0] id, logic [7:0] preq,
                                logic [15:0] per);
        int g;
        g = gap_len();
        repeat ((g == 0 || $urandom_range(0, 4) == 0) ? 1 : g) @(negedge i_clk);
        i_valid <= 1;
        i_cmd <= cmd;
        i_task_id <= id;
        i_priority_req <= preq;
        i_period <= per;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(cmd, id, preq, per);
        @(negedge i_clk);
        i_valid <= 0;
    endtask

    task automatic write_max_priority(logic [6:0] v);
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.max_prio = v;
    endtask

    task automatic random_request();
        int r;
        t_cmd c;
        logic [7:0] id;
        logic [15:0] per;
        r = $urandom_range(0, 99);
        c = r < 25 ? CMD_CREATE : r < 40 ? CMD_DELETE : r < 65 ? CMD_TICK : CMD_SCHED;
        id = $urandom_range(0, 15) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 12);
        r = $urandom_range(0, 9);
        per = r < 7 ? $urandom_range(0, 6) : r < 9 ? $urandom_range(0, 300)
                                                   : $urandom_range(0, 65535);
        send_request(c, id, $urandom_range(0, 255), per);
    endtask

    initial begin
        logic [6:0] cfgs[5] = '{7'd127, 7'd1, 7'd0, 7'd50, 7'd10};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_request(CMD_CREATE, 0, 5, 1);
        send_request(CMD_DELETE, 0, 0, 0);
        send_request(CMD_DELETE, 99, 0, 0);
        send_request(CMD_SCHED, 0, 0, 0);
        send_request(CMD_CREATE, 8'hFF, 8'hFF, 16'hFFFF);
        send_request(CMD_CREATE, 1, 0, 2);
        send_request(CMD_CREATE, 2, 3, 0);
        send_request(CMD_CREATE, 2, 3, 1);
        send_request(CMD_CREATE, 3, 10, 3);
        send_request(CMD_CREATE, 4, 9, 2);
        send_request(CMD_CREATE, 5, 8, 16'h8000);
        send_request(CMD_CREATE, 6, 10, 1);
        send_request(CMD_CREATE, 7, 1, 1);
        send_request(CMD_SCHED, 0, 0, 0);
        send_request(CMD_SCHED, 0, 0, 0);
        send_request(CMD_TICK, 0, 0, 0);
        send_request(CMD_SCHED, 0, 0, 0);
        send_request(CMD_DELETE, 2, 0, 0);
        send_request(CMD_SCHED, 0, 0, 0);
        for (int ph = 0; ph < 5; ph++) begin
            write_max_priority(cfgs[ph]);
            for (int i = 0; i < 230; i++) random_request();
        end
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
